FILE: hw/rtl/circular_deque_defines.svh
// Assertion macros for the circular deque.
// Used by the top level through `include; no other dependencies.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define CDQ_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("circular_deque assertion failed");
// Next-cycle implication, checked outside reset.
`define CDQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("circular_deque assertion failed");
`else
`define CDQ_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define CDQ_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: hw/rtl/cdq_pkg.sv
// Shared types and codes for the circular deque.
// No dependencies; imported by cdq_ctrl and circular_deque.
`timescale 1ns / 1ps

package cdq_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_RSVD      = 2'd3
    } status_t;

    localparam int FILL_W = 4;
    localparam int DATA_W = 32;

    // Result of one action, minus the popped word (that comes from memory).
    typedef struct packed {
        logic              pop_ok;
        status_t           status;
        logic [FILL_W-1:0] fill;
    } cdq_resp_t;

endpackage

FILE: hw/rtl/circular_deque.sv
// Top level of the circular deque: handshakes, result staging, assertions.
// Depends on cdq_pkg, cdq_ctrl, cdq_mem and circular_deque_defines.svh.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_valid / s_ready  | s_action[1:0], s_value[31:0] signed
//   m_      | out | m_valid / m_ready  | m_popped_value[31:0] signed,
//           |     |                    | m_status[1:0], m_fill_count[3:0]
//
// For each item, the accept edge updates the indices and issues the memory
// access, and the next edge loads the result (with the read word).
// s_ready waits for the staging stage to clear and the output register to be
// empty or draining, so no new item is taken while the last one is staged.
// Reset (aresetn low, synchronous) empties the deque; entry contents are not
// cleared, since a pop only reads entries that a push has written.
`timescale 1ns / 1ps
`include "circular_deque_defines.svh"

module circular_deque #(
    parameter int DEPTH = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_popped_value,
    output logic [1:0]         m_status,
    output logic [3:0]         m_fill_count
);

    import cdq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);

    logic              accept;
    logic              mem_wr_en, mem_rd_en;
    logic [IDX_W-1:0]  mem_wr_addr, mem_rd_addr;
    logic [DATA_W-1:0] mem_wr_data, mem_rd_data;
    cdq_resp_t         resp;

    // staging stage: holds the response until the memory read word is registered
    logic              pend_valid_reg, pend_valid_next;
    cdq_resp_t         pend_resp_reg;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_popped_reg;
    status_t           m_status_reg;
    logic [FILL_W-1:0] m_fill_reg;

    // Output register is always free by the time the stage completes:
    // it was empty or drained at the accept edge.
    assign s_ready = !pend_valid_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .OCC_W (OCC_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (accept),
        .action  (s_action),
        .value   (s_value),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .resp    (resp)
    );

    cdq_mem #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W),
        .IDX_W  (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign pend_valid_next = accept;
    assign m_valid_next    = pend_valid_reg || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_resp_reg <= resp;
        end
        if (pend_valid_reg) begin
            m_popped_reg <= pend_resp_reg.pop_ok ? mem_rd_data : '0;
            m_status_reg <= pend_resp_reg.status;
            m_fill_reg   <= pend_resp_reg.fill;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_value = m_popped_reg;
    assign m_status       = m_status_reg;
    assign m_fill_count   = m_fill_reg;

    // every accepted item reaches the staging stage next cycle
    `CDQ_ASSERT_NEXT(a_accept_stages, aclk, aresetn, accept, pend_valid_reg)
    // a staged result never lands on an occupied output register
    `CDQ_ASSERT_IMPL(a_stage_out_free, aclk, aresetn, pend_valid_reg, !m_valid_reg)
    // an underflow only happens on an empty deque and returns zero
    `CDQ_ASSERT_IMPL(a_underflow_empty, aclk, aresetn, m_valid && (m_status == ST_UNDERFLOW), (m_popped_value == '0) && (m_fill_count == '0))

endmodule

FILE: hw/rtl/cdq_mem.sv
// Entry storage for the circular deque: one write port, one read port,
// registered read data. Depends on nothing.
`timescale 1ns / 1ps

module cdq_mem #(
    parameter int DEPTH  = 8,
    parameter int DATA_W = 32,
    parameter int IDX_W  = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/cdq_ctrl.sv
// Index and occupancy control for the circular deque: decodes an action,
// issues the memory access and updates front/rear/occupancy. Uses cdq_pkg.
`timescale 1ns / 1ps

module cdq_ctrl #(
    parameter int DEPTH = 8,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int OCC_W = $clog2(DEPTH + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              issue,
    input  logic [1:0]                        action,
    input  logic [cdq_pkg::DATA_W-1:0]        value,
    output logic                              wr_en,
    output logic [IDX_W-1:0]                  wr_addr,
    output logic [cdq_pkg::DATA_W-1:0]        wr_data,
    output logic                              rd_en,
    output logic [IDX_W-1:0]                  rd_addr,
    output cdq_pkg::cdq_resp_t                resp
);

    import cdq_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] rear_reg,  rear_next;
    logic [OCC_W-1:0] occ_reg,   occ_next;
    logic [OCC_W+FILL_W-1:0] occ_ext;
    logic [IDX_W-1:0] front_inc, front_dec, rear_inc, rear_dec;
    logic empty, full;

    assign empty     = (occ_reg == '0);
    assign full      = (occ_reg == FULL_OCC);
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign rear_inc  = (rear_reg == LAST_IDX) ? '0 : rear_reg + 1'b1;
    assign rear_dec  = (rear_reg == '0) ? LAST_IDX : rear_reg - 1'b1;

    always_comb begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        occ_next    = occ_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        resp.pop_ok = 1'b0;
        resp.status = ST_DONE;
        case (action_t'(action))
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                if (full) begin
                    resp.status = ST_OVERFLOW;
                end else begin
                    wr_en    = issue;
                    occ_next = occ_reg + 1'b1;
                    if (empty) begin
                        front_next = '0;
                        rear_next  = '0;
                        wr_addr    = '0;
                    end else if (action_t'(action) == ACT_PUSH_FRONT) begin
                        front_next = front_dec;
                        wr_addr    = front_dec;
                    end else begin
                        rear_next = rear_inc;
                        wr_addr   = rear_inc;
                    end
                end
            end
            ACT_POP_FRONT, ACT_POP_REAR: begin
                if (empty) begin
                    resp.status = ST_UNDERFLOW;
                end else begin
                    rd_en       = issue;
                    resp.pop_ok = 1'b1;
                    occ_next    = occ_reg - 1'b1;
                    if (action_t'(action) == ACT_POP_FRONT) begin
                        rd_addr    = front_reg;
                        front_next = front_inc;
                    end else begin
                        rd_addr   = rear_reg;
                        rear_next = rear_dec;
                    end
                    // last entry gone: both indices home
                    if (occ_reg == OCC_W'(1)) begin
                        front_next = '0;
                        rear_next  = '0;
                    end
                end
            end
            default: begin
                resp.status = ST_DONE;
            end
        endcase
        occ_ext   = {{FILL_W{1'b0}}, occ_next};
        resp.fill = occ_ext[FILL_W-1:0];
    end

    assign wr_data = value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            rear_reg  <= '0;
            occ_reg   <= '0;
        end else if (issue) begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            occ_reg   <= occ_next;
        end
    end

endmodule
